// ===== design/sle_pkg.sv =====
// Shared codes and field widths for the sorted list engine.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package sle_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int CNT_W   = 5;

    localparam logic [1:0] KIND_INSERT     = 2'd0;
    localparam logic [1:0] KIND_REMOVE_AT  = 2'd1;
    localparam logic [1:0] KIND_REMOVE_VAL = 2'd2;
    localparam logic [1:0] KIND_FIND       = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [CNT_W-1:0] NO_INDEX = 5'h1F;

endpackage

// ===== design/sle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sorted_list_engine_unit.sv =====
// Sorted list engine: ascending list of signed words held in one RAM.
// Depends on sle_pkg and sle_ram.
// Result strobe: in the cycle after start for refused or trivial operations,
// otherwise once the RAM walk ends; one RAM step a cycle.
// Throughput: one operation at a time; busy is high while the RAM walk runs.
// Reset clears the count and the control and result registers; entries stay undefined until written.
`timescale 1ns / 1ps

module sorted_list_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           kind,
    input  logic signed [sle_pkg::VALUE_W-1:0]   value,
    input  logic [sle_pkg::POS_W-1:0]            position,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic signed [sle_pkg::CNT_W-1:0]     found_index,
    output logic [sle_pkg::CNT_W-1:0]            removed_count,
    output logic [sle_pkg::CNT_W-1:0]            count_now
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                       state_reg, state_next;
    logic [1:0]                   kind_reg;
    logic [sle_pkg::VALUE_W-1:0]  value_reg;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                ptr_reg, ptr_next;
    logic [CW-1:0]                wr_reg, wr_next;
    logic [CW-1:0]                rem_reg, rem_next;
    logic                         done_reg, done_next;
    logic [1:0]                   status_reg, status_next;
    logic [sle_pkg::CNT_W-1:0]    found_reg, found_next;
    logic [sle_pkg::CNT_W-1:0]    removed_reg, removed_next;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [sle_pkg::VALUE_W-1:0]  mem_wdata;
    logic [AW-1:0]                mem_raddr;
    logic [sle_pkg::VALUE_W-1:0]  mem_rdata;

    logic [XW-1:0]                pos_x, cnt_x, ptr_x, wr_x;
    logic [31:0]                  cnt_wide, ptr_wide, rem_wide;

    assign pos_x = XW'(position);
    assign cnt_x = XW'(count_reg);
    assign ptr_x = XW'(ptr_reg);
    assign wr_x  = XW'(wr_reg);

    assign cnt_wide = 32'(count_reg);
    assign ptr_wide = 32'(ptr_reg);

    sle_ram #(
        .WIDTH(sle_pkg::VALUE_W),
        .DEPTH(CAPACITY)
    ) u_entries (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Writes always land at or behind the entries already read, so no forwarding is needed.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        wr_next      = wr_reg;
        rem_next     = rem_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        found_next   = found_reg;
        removed_next = removed_reg;
        rem_wide     = 32'd0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = value_reg;
        mem_raddr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next  = sle_pkg::ST_OK;
                    found_next   = sle_pkg::NO_INDEX;
                    removed_next = '0;
                    unique case (kind)
                        sle_pkg::KIND_INSERT:
                        begin
                            if (cnt_x == XW'(CAPACITY))
                            begin
                                status_next = sle_pkg::ST_FULL;
                                done_next   = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = value;
                                count_next = CW'(1);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = AW'(cnt_x - XW'(1));
                                ptr_next   = count_reg;
                                state_next = S_RUN;
                            end
                        end
                        sle_pkg::KIND_REMOVE_AT:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                status_next = sle_pkg::ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (pos_x + XW'(1) >= cnt_x)
                            begin
                                count_next   = count_reg - CW'(1);
                                removed_next = sle_pkg::CNT_W'(1);
                                done_next    = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = AW'(pos_x + XW'(1));
                                ptr_next   = CW'(pos_x);
                                state_next = S_RUN;
                            end
                        end
                        sle_pkg::KIND_REMOVE_VAL:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = sle_pkg::ST_NOTFOUND;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                ptr_next   = '0;
                                wr_next    = '0;
                                rem_next   = '0;
                                state_next = S_RUN;
                            end
                        end
                        sle_pkg::KIND_FIND:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                status_next = sle_pkg::ST_NOTFOUND;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = AW'(pos_x);
                                ptr_next   = CW'(pos_x);
                                state_next = S_RUN;
                            end
                        end
                    endcase
                end
            end

            S_RUN:
            begin
                unique case (kind_reg)
                    sle_pkg::KIND_INSERT:
                    begin
                        // Walk down from the top, moving larger entries up one slot.
                        if (ptr_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            count_next = count_reg + CW'(1);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if ($signed(mem_rdata) > $signed(value_reg))
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(ptr_x);
                            mem_wdata = mem_rdata;
                            mem_raddr = AW'(ptr_x - XW'(2));
                            ptr_next  = ptr_reg - CW'(1);
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(ptr_x);
                            count_next = count_reg + CW'(1);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    sle_pkg::KIND_REMOVE_AT:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(ptr_x);
                        mem_wdata = mem_rdata;
                        mem_raddr = AW'(ptr_x + XW'(2));
                        ptr_next  = ptr_reg + CW'(1);
                        if (ptr_x + XW'(2) >= cnt_x)
                        begin
                            count_next   = count_reg - CW'(1);
                            removed_next = sle_pkg::CNT_W'(1);
                            done_next    = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    sle_pkg::KIND_REMOVE_VAL:
                    begin
                        // Compact in place: keep unequal entries, count the dropped ones.
                        if (mem_rdata == value_reg)
                        begin
                            rem_next = rem_reg + CW'(1);
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(wr_x);
                            mem_wdata = mem_rdata;
                            wr_next   = wr_reg + CW'(1);
                        end
                        mem_raddr = AW'(ptr_x + XW'(1));
                        ptr_next  = ptr_reg + CW'(1);
                        if (ptr_x + XW'(1) >= cnt_x)
                        begin
                            rem_wide     = 32'(rem_next);
                            count_next   = wr_next;
                            removed_next = rem_wide[sle_pkg::CNT_W-1:0];
                            if (rem_next == '0)
                            begin
                                status_next = sle_pkg::ST_NOTFOUND;
                            end
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    sle_pkg::KIND_FIND:
                    begin
                        mem_raddr = AW'(ptr_x + XW'(1));
                        ptr_next  = ptr_reg + CW'(1);
                        if (mem_rdata == value_reg)
                        begin
                            found_next = ptr_wide[sle_pkg::CNT_W-1:0];
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (ptr_x + XW'(1) >= cnt_x)
                        begin
                            status_next = sle_pkg::ST_NOTFOUND;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            kind_reg    <= sle_pkg::KIND_INSERT;
            ptr_reg     <= '0;
            wr_reg      <= '0;
            rem_reg     <= '0;
            status_reg  <= sle_pkg::ST_OK;
            found_reg   <= sle_pkg::NO_INDEX;
            removed_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            ptr_reg     <= ptr_next;
            wr_reg      <= wr_next;
            rem_reg     <= rem_next;
            status_reg  <= status_next;
            found_reg   <= found_next;
            removed_reg <= removed_next;
            if (state_reg == S_IDLE && start)
            begin
                kind_reg <= kind;
            end
        end
    end

    // Operand register: no reset needed.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            value_reg <= value;
        end
    end

    assign busy          = (state_reg == S_RUN);
    assign done          = done_reg;
    assign status        = status_reg;
    assign found_index   = found_reg;
    assign removed_count = removed_reg;
    assign count_now     = cnt_wide[sle_pkg::CNT_W-1:0];

endmodule

// ===== design/sle_checker.sv =====
// Port-level checks for the sorted list engine, bound to the top level.
// Depends on sle_pkg and sorted_list_engine_unit.
`timescale 1ns / 1ps

module sle_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        busy,
    input logic                        done,
    input logic [1:0]                  status,
    input logic [sle_pkg::CNT_W-1:0]   found_index,
    input logic [sle_pkg::CNT_W-1:0]   removed_count,
    input logic [sle_pkg::CNT_W-1:0]   count_now
);

    // No result while a walk is still running.
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe while busy");

    // A walk always ends with a result.
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("walk ended without a result");

    // Refused operations leave the count alone.
    a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == sle_pkg::ST_RANGE || status == sle_pkg::ST_FULL)
        |-> $stable(count_now))
        else $error("refused operation changed the count");

    // A full list reports nothing removed and no index.
    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == sle_pkg::ST_FULL
        |-> removed_count == '0 && found_index == sle_pkg::NO_INDEX)
        else $error("full status with stray fields");

endmodule

bind sorted_list_engine_unit sle_checker u_sle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .found_index  (found_index),
    .removed_count(removed_count),
    .count_now    (count_now)
);

// ===== test/tb_sorted_list_engine_unit.sv =====
// Self-checking testbench for sorted_list_engine_unit: directed corner cases, then
// random insert/remove/find traffic checked against an in-bench copy of the sorted list.
// Depends on sle_pkg and the design sources only.
`timescale 1ns / 1ps

module tb_sorted_list_engine_unit;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_OPS   = 1000;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE       = CAPACITY + 4;

    typedef struct packed {
        logic [1:0]                         kind;
        logic signed [sle_pkg::VALUE_W-1:0] value;
        logic [sle_pkg::POS_W-1:0]          position;
    } list_op_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [sle_pkg::CNT_W-1:0] found_index;
        logic [sle_pkg::CNT_W-1:0] removed_count;
        logic [sle_pkg::CNT_W-1:0] count_now;
    } list_reply_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic [1:0]                         kind = sle_pkg::KIND_INSERT;
    logic signed [sle_pkg::VALUE_W-1:0] value = '0;
    logic [sle_pkg::POS_W-1:0]          position = '0;
    logic                               busy;
    logic                               done;
    logic [1:0]                         status;
    logic signed [sle_pkg::CNT_W-1:0]   found_index;
    logic [sle_pkg::CNT_W-1:0]          removed_count;
    logic [sle_pkg::CNT_W-1:0]          count_now;

    list_op_t    pending_ops[$];
    list_reply_t expected_replies[$];

    logic signed [sle_pkg::VALUE_W-1:0] shadow_list[CAPACITY];
    int                                 shadow_len = 0;
    logic signed [sle_pkg::VALUE_W-1:0] value_pool[12];

    int transfers = 0;
    int errors    = 0;
    int cycles    = 0;

    sorted_list_engine_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .value        (value),
        .position     (position),
        .done         (done),
        .status       (status),
        .found_index  (found_index),
        .removed_count(removed_count),
        .count_now    (count_now)
    );

    always #10 clk = ~clk;

    // Apply one operation to the shadow list and return the reply it should give.
    function automatic list_reply_t apply_list_op(input list_op_t op);
        list_reply_t r;
        int          i;
        int          w;
        int          removed;
        r.status        = sle_pkg::ST_OK;
        r.found_index   = sle_pkg::NO_INDEX;
        r.removed_count = '0;
        removed         = 0;
        case (op.kind)
            sle_pkg::KIND_INSERT:
            begin
                if (shadow_len >= CAPACITY)
                begin
                    r.status = sle_pkg::ST_FULL;
                end
                else
                begin
                    i = shadow_len;
                    while (i > 0 && shadow_list[i-1] > op.value)
                    begin
                        shadow_list[i] = shadow_list[i-1];
                        i--;
                    end
                    shadow_list[i] = op.value;
                    shadow_len++;
                end
            end
            sle_pkg::KIND_REMOVE_AT:
            begin
                if (int'(op.position) >= shadow_len)
                begin
                    r.status = sle_pkg::ST_RANGE;
                end
                else
                begin
                    for (i = int'(op.position); i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                    removed = 1;
                end
            end
            sle_pkg::KIND_REMOVE_VAL:
            begin
                w = 0;
                for (i = 0; i < shadow_len; i++)
                begin
                    if (shadow_list[i] == op.value)
                        removed++;
                    else
                    begin
                        shadow_list[w] = shadow_list[i];
                        w++;
                    end
                end
                shadow_len = w;
                if (removed == 0)
                    r.status = sle_pkg::ST_NOTFOUND;
            end
            default:
            begin
                r.status = sle_pkg::ST_NOTFOUND;
                for (i = int'(op.position); i < shadow_len; i++)
                begin
                    if (shadow_list[i] == op.value)
                    begin
                        r.status      = sle_pkg::ST_OK;
                        r.found_index = i[sle_pkg::CNT_W-1:0];
                        break;
                    end
                end
            end
        endcase
        r.removed_count = removed[sle_pkg::CNT_W-1:0];
        r.count_now     = shadow_len[sle_pkg::CNT_W-1:0];
        return r;
    endfunction

    // Mostly reuse a small pool so finds and removals hit; otherwise any word.
    function automatic logic signed [sle_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 70)
            return value_pool[$urandom_range(0, 11)];
        return $urandom;
    endfunction

    function automatic int sender_idle_pct();
        if (transfers < 375)
            return 38;
        if (transfers < 700)
            return 57;
        return 0;
    endfunction

    task automatic queue_op(input logic [1:0] k, input logic signed [sle_pkg::VALUE_W-1:0] v,
                            input logic [sle_pkg::POS_W-1:0] p);
        pending_ops.push_back('{kind: k, value: v, position: p});
    endtask

    task automatic note_error();
        errors++;
    endtask

    // Driver: predict on each transfer, then hold, present the next item or idle.
    always @(posedge clk or negedge rst_n)
    begin
        list_op_t nxt;
        bit       take;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            take = 1'b0;
            if (start && !busy)
            begin
                expected_replies.push_back(apply_list_op('{kind: kind, value: value,
                                                           position: position}));
                transfers++;
            end
            if (!(start && busy) && pending_ops.size() > 0 &&
                $urandom_range(0, 99) >= sender_idle_pct())
                take = 1'b1;
            if (start && busy)
            begin
                // hold the item until the engine takes it
            end
            else if (take)
            begin
                nxt = pending_ops.pop_front();
                kind     <= nxt.kind;
                value    <= nxt.value;
                position <= nxt.position;
                start    <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest outstanding expectation.
    always @(posedge clk)
    begin
        list_reply_t want;
        list_reply_t got;
        if (rst_n && done)
        begin
            got = '{status: status, found_index: found_index,
                    removed_count: removed_count, count_now: count_now};
            if (expected_replies.size() == 0)
            begin
                note_error();
                if (errors <= 10)
                    $display("cycle %0d: unexpected result, status %0d count_now %0d",
                             cycles, got.status, got.count_now);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got.status !== want.status || got.found_index !== want.found_index ||
                    got.removed_count !== want.removed_count ||
                    got.count_now !== want.count_now)
                begin
                    note_error();
                    if (errors <= 10)
                        $display("cycle %0d: exp/act st %0d/%0d idx %0d/%0d rem %0d/%0d cnt %0d/%0d",
                                 cycles, want.status, got.status,
                                 $signed(want.found_index), $signed(got.found_index),
                                 want.removed_count, got.removed_count,
                                 want.count_now, got.count_now);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        bit filling;
        int n;
        int ins_pct;
        logic [1:0] k;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (n = 4; n < 12; n++)
            value_pool[n] = $urandom;

        // Empty list: nothing to find or remove.
        queue_op(sle_pkg::KIND_FIND, 32'sd0, 4'd0);
        queue_op(sle_pkg::KIND_REMOVE_AT, 32'sd0, 4'd0);
        queue_op(sle_pkg::KIND_REMOVE_VAL, 32'sd0, 4'd0);
        // Extremes, then fill to capacity with repeated values.
        queue_op(sle_pkg::KIND_INSERT, 32'h7FFF_FFFF, 4'd15);
        queue_op(sle_pkg::KIND_INSERT, 32'h8000_0000, 4'd0);
        queue_op(sle_pkg::KIND_INSERT, 32'sd0, 4'd0);
        queue_op(sle_pkg::KIND_INSERT, -32'sd1, 4'd0);
        queue_op(sle_pkg::KIND_INSERT, 32'sd5, 4'd0);
        for (n = 0; n < 11; n++)
            queue_op(sle_pkg::KIND_INSERT, (n % 3 == 0) ? 32'sd5 : $urandom,
                     sle_pkg::POS_W'($urandom));
        queue_op(sle_pkg::KIND_INSERT, 32'sd7, 4'd0);            // refused: list full
        queue_op(sle_pkg::KIND_FIND, 32'sd5, 4'd15);             // start past every 5
        queue_op(sle_pkg::KIND_FIND, 32'sd5, 4'd0);
        queue_op(sle_pkg::KIND_REMOVE_AT, 32'sd0, 4'd15);        // drop the last entry
        queue_op(sle_pkg::KIND_REMOVE_VAL, 32'sd5, 4'd0);        // drop every 5
        queue_op(sle_pkg::KIND_FIND, 32'h8000_0000, 4'd15);      // start beyond count
        queue_op(sle_pkg::KIND_REMOVE_AT, 32'sd0, 4'd15);        // index beyond count

        // Alternate fill and drain stretches so the count sweeps its range.
        filling = 1'b0;
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 40 == 0)
                filling = ~filling;
            ins_pct = filling ? 65 : 20;
            if ($urandom_range(0, 99) < ins_pct)
                k = sle_pkg::KIND_INSERT;
            else
                k = 2'($urandom_range(1, 3));
            queue_op(k, pick_value(), sle_pkg::POS_W'($urandom));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() > 0 || start || expected_replies.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (expected_replies.size() > 0)
            $display("%0d results never arrived", expected_replies.size());
        if (errors == 0 && expected_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
